// ----- rtl/core/crs_pkg.sv -----
package crs_pkg;

    localparam int STACKS     = 16;
    localparam int HEIGHT     = 8;
    localparam int SW         = $clog2(STACKS);
    localparam int TW         = $clog2(HEIGHT);
    localparam int HW         = $clog2(HEIGHT + 1);
    localparam int SLOTS      = STACKS * HEIGHT;
    localparam int AW         = $clog2(SLOTS);

    localparam logic [1:0] CFG_MAX_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_NUM_STACKS = 2'd1;
    localparam logic [1:0] CFG_BOUND      = 2'd2;

    localparam logic [1:0] HEUR_SPACE   = 2'd0;
    localparam logic [1:0] HEUR_BLOCKED = 2'd1;
    localparam logic [1:0] HEUR_RI      = 2'd2;
    localparam logic [1:0] HEUR_RIL     = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOP,
        S_SCAN,
        S_DECIDE,
        S_WRITE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic load_top;
        logic step;
        logic decide;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic is_load;
        logic early_done;
        logic scan_done;
    } stat_t;

endpackage

// ----- rtl/core/crs_ctrl.sv -----
module crs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_beat,
    input  crs_pkg::stat_t stat,
    input  logic           out_beat,
    output crs_pkg::ctrl_t ctrl,
    output logic           busy,
    output logic           out_valid
);

    crs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            crs_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (in_beat)
                begin
                    ctrl.start = 1'b1;
                    state_next = crs_pkg::S_TOP;
                end
            end
            crs_pkg::S_TOP:
            begin
                ctrl.load_top = 1'b1;
                if (stat.early_done)
                    state_next = crs_pkg::S_OUT;
                else if (stat.is_load)
                    state_next = crs_pkg::S_WRITE;
                else
                    state_next = crs_pkg::S_SCAN;
            end
            crs_pkg::S_SCAN:
            begin
                ctrl.step = 1'b1;
                if (stat.scan_done)
                    state_next = crs_pkg::S_DECIDE;
            end
            crs_pkg::S_DECIDE:
            begin
                ctrl.decide = 1'b1;
                state_next  = crs_pkg::S_WRITE;
            end
            crs_pkg::S_WRITE:
            begin
                ctrl.commit = 1'b1;
                state_next  = crs_pkg::S_OUT;
            end
            crs_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_beat)
                    state_next = crs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = crs_pkg::S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> state_reg == crs_pkg::S_TOP)
        else $error("start did not enter top read");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crs_pkg::S_OUT && !out_beat) |=> state_reg == crs_pkg::S_OUT)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> state_reg == crs_pkg::S_OUT)
        else $error("commit not followed by result");

endmodule

// ----- rtl/core/crs_datapath.sv -----
module crs_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  crs_pkg::ctrl_t ctrl,
    output crs_pkg::stat_t stat,
    input  logic           cfg_beat,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic           opcode,
    input  logic [3:0]     stack_index,
    input  logic [6:0]     container_id,
    input  logic [1:0]     heuristic,
    output logic [3:0]     dest_stack,
    output logic [6:0]     moved_container,
    output logic [1:0]     heuristic_used,
    output logic [1:0]     status
);

    localparam int SWN = crs_pkg::SW;

    logic [3:0] max_height_reg;
    logic [4:0] num_stacks_reg;
    logic [7:0] bound_reg;

    logic [crs_pkg::HW-1:0] heights_reg [crs_pkg::STACKS];
    logic [6:0] yard_mem [crs_pkg::SLOTS];
    logic [6:0] rd_data_reg;

    logic            op_reg;
    logic [SWN-1:0]  org_reg;
    logic [6:0]      cid_reg;
    logic [1:0]      heur_reg;
    logic [3:0]      dest_reg;
    logic [6:0]      moved_reg;
    logic [1:0]      status_reg;
    logic [1:0]      heuristic_used_reg;
    logic            top_wait_reg;

    // Scan position: stack i, tier t; the read is registered, so the
    // compare comes in the cycle after the read (pend_*).
    logic [SWN-1:0]        si_reg;
    logic [crs_pkg::TW:0]  ti_reg;
    logic                  pend_reg, pend_last_reg;
    logic [SWN-1:0]        pend_s_reg;
    logic [7:0]            cnt_reg;
    logic [6:0]            hi_reg;
    logic                  scan_end_reg;

    logic [8:0]      best_reg;
    logic [SWN-1:0]  bdest_reg;
    logic [6:0]      bhi_reg;
    logic            ril_hit_reg;

    logic [crs_pkg::HW-1:0] mh;
    logic [SWN:0]           ns;

    always_comb
    begin
        mh = (max_height_reg > 4'(crs_pkg::HEIGHT)) ? crs_pkg::HW'(crs_pkg::HEIGHT)
                                                    : crs_pkg::HW'(max_height_reg);
        ns = (num_stacks_reg > 5'(crs_pkg::STACKS)) ? (SWN+1)'(crs_pkg::STACKS)
                                                    : (SWN+1)'(num_stacks_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_height_reg <= 4'd8;
            num_stacks_reg <= 5'd16;
            bound_reg      <= 8'd128;
        end
        else if (cfg_beat)
        begin
            unique case (cfg_index)
                crs_pkg::CFG_MAX_HEIGHT: max_height_reg <= cfg_data[3:0];
                crs_pkg::CFG_NUM_STACKS: num_stacks_reg <= cfg_data[4:0];
                crs_pkg::CFG_BOUND:      bound_reg      <= cfg_data;
                default:                 ;
            endcase
        end
    end

    logic [crs_pkg::HW-1:0] h_org;
    logic [crs_pkg::HW-1:0] h_cur;
    logic                   skip_cur;
    logic                   scan_pass;
    logic                   scan_hit;
    logic                   scan_rd;
    logic [crs_pkg::AW-1:0] rd_addr;
    logic                   rd_en;

    assign h_org = heights_reg[org_reg];
    assign h_cur = heights_reg[si_reg];
    assign skip_cur = (si_reg == org_reg) || (h_cur == mh);

    // A stack is passed over, taken at once as an empty RIL
    // target, or read slot by slot.
    assign scan_pass = (heur_reg == crs_pkg::HEUR_SPACE) || skip_cur || ril_hit_reg;
    assign scan_hit  = (heur_reg == crs_pkg::HEUR_RIL) && (h_cur == '0);
    assign scan_rd   = !scan_end_reg && !pend_last_reg && !scan_pass && !scan_hit
                    && (ti_reg < (crs_pkg::TW+1)'(h_cur));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = crs_pkg::AW'(org_reg) * crs_pkg::AW'(crs_pkg::HEIGHT)
                + crs_pkg::AW'(h_org - 1'b1);
        if (ctrl.load_top)
            rd_en = 1'b1;
        else if (ctrl.step && scan_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = crs_pkg::AW'(si_reg) * crs_pkg::AW'(crs_pkg::HEIGHT)
                    + crs_pkg::AW'(ti_reg);
        end
    end

    // Destination chosen from the running best.
    logic [SWN-1:0]         dsel;
    logic [crs_pkg::HW-1:0] h_dst;
    assign dsel  = ril_hit_reg ? bdest_reg : bdest_reg;
    assign h_dst = heights_reg[dsel];

    logic [crs_pkg::AW-1:0] wr_addr;
    logic [SWN-1:0]         wr_s;
    logic [crs_pkg::HW-1:0] wr_h;
    always_comb
    begin
        wr_s = op_reg ? dest_reg[SWN-1:0] : org_reg;
        wr_h = heights_reg[wr_s];
        if (op_reg && wr_s == org_reg)
            wr_h = wr_h - 1'b1;
        wr_addr = crs_pkg::AW'(wr_s) * crs_pkg::AW'(crs_pkg::HEIGHT)
                + crs_pkg::AW'(wr_h[crs_pkg::TW-1:0]);
    end

    logic do_write;
    assign do_write = ctrl.commit && (status_reg == crs_pkg::ST_OK);

    always_ff @(posedge clk)
    begin
        if (do_write)
            yard_mem[wr_addr] <= op_reg ? moved_reg : cid_reg;
        if (rd_en)
            rd_data_reg <= yard_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < crs_pkg::STACKS; k++)
                heights_reg[k] <= '0;
        end
        else if (do_write)
        begin
            // A move back onto the origin leaves its height unchanged.
            if (op_reg && wr_s != org_reg)
                heights_reg[org_reg] <= heights_reg[org_reg] - 1'b1;
            heights_reg[wr_s] <= wr_h + 1'b1;
        end
    end

    // Item fields, early checks and result.
    logic [8:0] cnt9;
    logic [8:0] start_best;
    assign cnt9 = {1'b0, cnt_reg};

    always_comb
    begin
        if (heur_reg == crs_pkg::HEUR_BLOCKED)
            start_best = {1'b0, bound_reg};
        else if (heur_reg == crs_pkg::HEUR_SPACE)
            start_best = '0;
        else
            start_best = 9'(heights_reg[0]);
    end

    logic load_bad;
    assign load_bad = ({1'b0, org_reg} >= ns) || (h_org >= mh);

    logic scan_last;
    assign scan_last = ({1'b0, si_reg} + 1'b1) >= ns;

    logic [8:0] sp_v;
    assign sp_v = 9'(mh) - 9'(h_cur);

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            op_reg   <= opcode;
            org_reg  <= stack_index[SWN-1:0];
            cid_reg  <= container_id;
            heur_reg <= heuristic;
        end
        if (ctrl.load_top)
        begin
            si_reg        <= '0;
            ti_reg        <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            cnt_reg       <= '0;
            hi_reg        <= '0;
            scan_end_reg  <= 1'b0;
            best_reg      <= start_best;
            bdest_reg     <= '0;
            bhi_reg       <= '0;
            ril_hit_reg   <= 1'b0;
            heuristic_used_reg <= op_reg ? heur_reg : 2'd0;
            if (!op_reg)
            begin
                dest_reg   <= 4'(org_reg);
                moved_reg  <= cid_reg;
                status_reg <= load_bad ? crs_pkg::ST_FULL : crs_pkg::ST_OK;
            end
            else if ({1'b0, org_reg} >= ns || h_org == '0)
            begin
                dest_reg   <= '0;
                moved_reg  <= '0;
                status_reg <= crs_pkg::ST_EMPTY;
            end
            else
            begin
                status_reg <= crs_pkg::ST_OK;
            end
        end
        // The top of the origin arrives in the cycle after the top read.
        if (top_wait_reg)
            moved_reg <= rd_data_reg;
        if (ctrl.step)
        begin
            if (pend_reg && rd_data_reg < moved_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (rd_data_reg > hi_reg)
                    hi_reg <= rd_data_reg;
            end
            pend_reg <= scan_rd;
            if (pend_last_reg)
            begin
                // Stack finished: fold the count into the running best.
                pend_last_reg <= 1'b0;
                cnt_reg <= '0;
                hi_reg  <= '0;
            end
            if (!scan_end_reg && !pend_last_reg)
            begin
                if (scan_pass)
                begin
                    if (heur_reg == crs_pkg::HEUR_SPACE && si_reg != org_reg
                        && h_cur < mh && sp_v > best_reg)
                    begin
                        best_reg  <= sp_v;
                        bdest_reg <= si_reg;
                    end
                    si_reg <= si_reg + 1'b1;
                    ti_reg <= '0;
                    if (scan_last)
                        scan_end_reg <= 1'b1;
                end
                else if (scan_hit)
                begin
                    ril_hit_reg <= 1'b1;
                    bdest_reg   <= si_reg;
                    scan_end_reg <= 1'b1;
                end
                else if (ti_reg < (crs_pkg::TW+1)'(h_cur))
                begin
                    ti_reg   <= ti_reg + 1'b1;
                end
                else
                begin
                    pend_last_reg <= 1'b1;
                    pend_s_reg    <= si_reg;
                    si_reg        <= si_reg + 1'b1;
                    ti_reg        <= '0;
                    if (scan_last)
                        scan_end_reg <= 1'b1;
                end
            end
        end
        if (ctrl.step && pend_last_reg)
        begin
            if (cnt9 < best_reg)
            begin
                best_reg  <= cnt9;
                bdest_reg <= pend_s_reg;
                bhi_reg   <= hi_reg;
            end
            else if (heur_reg == crs_pkg::HEUR_RIL && cnt9 == best_reg && hi_reg > bhi_reg)
            begin
                bdest_reg <= pend_s_reg;
                bhi_reg   <= hi_reg;
            end
        end
        if (ctrl.decide)
        begin
            dest_reg <= 4'(dsel);
            if (dsel != org_reg && h_dst >= mh)
                status_reg <= crs_pkg::ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            top_wait_reg <= 1'b0;
        else
            top_wait_reg <= ctrl.load_top && op_reg && !stat.early_done;
    end

    assign stat.is_load    = !op_reg;
    assign stat.early_done = (!op_reg && load_bad)
                          || (op_reg && ({1'b0, org_reg} >= ns || h_org == '0));
    assign stat.scan_done  = scan_end_reg && !pend_reg && !pend_last_reg && !top_wait_reg;

    assign dest_stack      = dest_reg;
    assign moved_container = moved_reg;
    assign heuristic_used  = heuristic_used_reg;
    assign status          = status_reg;

endmodule

// ----- rtl/core/container_relocation_selector.sv -----
// Sequence: a load reads the origin top, writes and gives its result beat; a relocate
// reads the top, scans the stacks (passing over a stack or reading it slot by slot),
// decides and writes before its result beat. A failed early check skips to the result.
// Throughput: one item at a time, the next input beat can come in the cycle after the result
// beat; the single yard memory read port reads one slot per cycle.
// Reset: stack heights clear to zero, registers go to 8, 16 and 128.
module container_relocation_selector (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [3:0] stack_index,
    input  logic [6:0] container_id,
    input  logic [1:0] heuristic,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] dest_stack,
    output logic [6:0] moved_container,
    output logic [1:0] heuristic_used,
    output logic [1:0] status
);

    crs_pkg::ctrl_t ctrl;
    crs_pkg::stat_t stat;
    logic busy;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;

    crs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (in_valid && in_ready),
        .stat      (stat),
        .out_beat  (out_valid && out_ready),
        .ctrl      (ctrl),
        .busy      (busy),
        .out_valid (out_valid)
    );

    crs_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .cfg_beat        (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .stack_index     (stack_index),
        .container_id    (container_id),
        .heuristic       (heuristic),
        .dest_stack      (dest_stack),
        .moved_container (moved_container),
        .heuristic_used  (heuristic_used),
        .status          (status)
    );

endmodule

// ----- test/container_relocation_selector_test.sv -----
module container_relocation_selector_test;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [3:0] stack_index;
    logic [6:0] container_id;
    logic [1:0] heuristic;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] dest_stack;
    logic [6:0] moved_container;
    logic [1:0] heuristic_used;
    logic [1:0] status;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_RELOCATE = 1'b1;
    localparam int   CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [3:0] dest;
        logic [6:0] moved;
        logic [1:0] used;
        logic [1:0] stat;
    } move_t;

    container_relocation_selector uut (.*);

    // Shadow yard that tracks the state of the block.
    logic [6:0] yard [crs_pkg::STACKS][crs_pkg::HEIGHT];
    int         heights [crs_pkg::STACKS];
    int         lim_height;
    int         lim_stacks;
    int         bound;

    move_t      pending_moves [$];
    int         mismatches;
    int         results_seen;
    int         cycles;
    bit         calm;
    int         n_loads;
    int         n_relocs;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic int eff_h();
        return (lim_height < crs_pkg::HEIGHT) ? lim_height : crs_pkg::HEIGHT;
    endfunction

    function automatic int eff_s();
        return (lim_stacks < crs_pkg::STACKS) ? lim_stacks : crs_pkg::STACKS;
    endfunction

    function automatic int smaller_count(int s, int c, output int hi);
        int n;
        n = 0;
        hi = 0;
        for (int t = 0; t < heights[s]; t++)
            if (yard[s][t] < c)
            begin
                n++;
                if (yard[s][t] > hi)
                    hi = yard[s][t];
            end
        return n;
    endfunction

    function automatic int choose_dest(int org, int c, logic [1:0] h);
        int best;
        int dest;
        int dhi;
        int n;
        int hi;
        int mh;
        mh = eff_h();
        dest = 0;
        dhi = 0;
        if (h == crs_pkg::HEUR_SPACE)
        begin
            best = 0;
            for (int i = 0; i < eff_s(); i++)
                if (i != org && mh - heights[i] > best)
                begin
                    best = mh - heights[i];
                    dest = i;
                end
            return dest;
        end
        best = (h == crs_pkg::HEUR_BLOCKED) ? bound : heights[0];
        for (int i = 0; i < eff_s(); i++)
        begin
            if (i == org || heights[i] == mh)
                continue;
            if (h == crs_pkg::HEUR_RIL && heights[i] == 0)
                return i;
            n = smaller_count(i, c, hi);
            if (n < best)
            begin
                best = n;
                dest = i;
                dhi = hi;
            end
            else if (h == crs_pkg::HEUR_RIL && n == best && hi > dhi)
            begin
                dest = i;
                dhi = hi;
            end
        end
        return dest;
    endfunction

    function automatic move_t predict_move(logic op, int si, int cid, logic [1:0] h);
        move_t r;
        int    c;
        int    d;
        r = '0;
        if (op == OP_LOAD)
        begin
            r.dest = 4'(si);
            r.moved = 7'(cid);
            if (si >= eff_s() || heights[si] >= eff_h())
                r.stat = crs_pkg::ST_FULL;
            else
            begin
                yard[si][heights[si]] = 7'(cid);
                heights[si]++;
            end
        end
        else
        begin
            r.used = h;
            if (si >= eff_s() || heights[si] == 0)
                r.stat = crs_pkg::ST_EMPTY;
            else
            begin
                c = yard[si][heights[si] - 1];
                r.moved = 7'(c);
                d = choose_dest(si, c, h);
                r.dest = 4'(d);
                if (d != si && heights[d] >= eff_h())
                    r.stat = crs_pkg::ST_FULL;
                else
                begin
                    heights[si]--;
                    yard[d][heights[d]] = 7'(c);
                    heights[d]++;
                end
            end
        end
        return r;
    endfunction

    // Valid stays high from one beat to the next unless an idle gap is taken.
    task automatic idle_burst();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic send_item(logic op, int si, int cid, logic [1:0] h);
        move_t m;
        idle_burst();
        opcode <= op;
        stack_index <= 4'(si);
        container_id <= 7'(cid);
        heuristic <= h;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        m = predict_move(op, si, cid, h);
        pending_moves = {pending_moves, m};
        if (op == OP_LOAD)
            n_loads++;
        else
            n_relocs++;
        @(negedge clk);
    endtask

    // Waits until the block has drained, plus the longest relocate scan.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        cfg_index <= idx;
        cfg_data <= 8'(val);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            crs_pkg::CFG_MAX_HEIGHT: lim_height = val & 8'h0f;
            crs_pkg::CFG_NUM_STACKS: lim_stacks = val & 8'h1f;
            crs_pkg::CFG_BOUND:      bound = val & 8'hff;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_yard(int mh, int ns, int b);
        drain();
        write_reg(crs_pkg::CFG_MAX_HEIGHT, mh);
        write_reg(crs_pkg::CFG_NUM_STACKS, ns);
        write_reg(crs_pkg::CFG_BOUND, b);
        cfg_valid <= 1'b0;
    endtask

    // Loads and relocates, mostly on stacks below ns_hint, now and then on any of the 16.
    task automatic random_items(int count, int ns_hint);
        int         si;
        logic       op;
        for (int k = 0; k < count; k++)
        begin
            op = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_RELOCATE;
            if ($urandom_range(0, 9) == 0)
                si = $urandom_range(0, 15);
            else
                si = $urandom_range(0, ns_hint - 1);
            send_item(op, si, $urandom_range(0, 127), 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_directed();
        send_item(OP_RELOCATE, 0, 0, crs_pkg::HEUR_SPACE);
        send_item(OP_RELOCATE, 15, 0, crs_pkg::HEUR_RIL);
        send_item(OP_LOAD, 0, 127, crs_pkg::HEUR_RIL);
        send_item(OP_LOAD, 0, 0, crs_pkg::HEUR_SPACE);
        send_item(OP_LOAD, 15, 64, crs_pkg::HEUR_SPACE);
        send_item(OP_LOAD, 3, 85, crs_pkg::HEUR_SPACE);
        send_item(OP_LOAD, 4, 42, crs_pkg::HEUR_SPACE);
        send_item(OP_RELOCATE, 0, 0, crs_pkg::HEUR_SPACE);
        send_item(OP_RELOCATE, 15, 0, crs_pkg::HEUR_BLOCKED);
        send_item(OP_RELOCATE, 3, 0, crs_pkg::HEUR_RI);
        send_item(OP_RELOCATE, 4, 0, crs_pkg::HEUR_RIL);
        for (int i = 0; i < 9; i++)
            send_item(OP_LOAD, 7, i * 14, crs_pkg::HEUR_SPACE);
    endtask

    task automatic test_config_extremes();
        // Two stacks of height one: moves fall back onto stack 0 or the origin.
        set_yard(1, 2, 0);
        send_item(OP_LOAD, 2, 5, crs_pkg::HEUR_SPACE);
        random_items(60, 2);
        set_yard(0, 2, 255);
        random_items(30, 2);
        // Lowered limit leaves tall stacks above it.
        set_yard(3, 31, 128);
        random_items(80, 16);
        set_yard(15, 16, 1);
        random_items(80, 16);
    endtask

    task automatic test_random();
        set_yard(8, 16, 128);
        random_items(400, 16);
        set_yard(4, 5, 3);
        random_items(250, 5);
        // Stall until the yard has settled, then keep going.
        drain();
        set_yard(6, 9, 200);
        random_items(300, 9);
        set_yard(8, 16, 128);
        random_items(250, 16);
        calm = 1'b1;
        random_items(150, 16);
    endtask

    initial
    begin
        move_t got;
        move_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = '{dest_stack, moved_container, heuristic_used, status};
                results_seen++;
                if (pending_moves.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", got);
                end
                else
                begin
                    want = pending_moves.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = crs_pkg::CFG_MAX_HEIGHT;
        cfg_data = 8'd0;
        in_valid = 1'b0;
        opcode = OP_LOAD;
        stack_index = 4'd0;
        container_id = 7'd0;
        heuristic = crs_pkg::HEUR_SPACE;
        out_ready = 1'b1;
        calm = 1'b0;
        mismatches = 0;
        results_seen = 0;
        n_loads = 0;
        n_relocs = 0;
        lim_height = 8;
        lim_stacks = 16;
        bound = 128;
        for (int s = 0; s < crs_pkg::STACKS; s++)
            heights[s] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_random();
        drain();
        if (pending_moves.size() != 0)
            mismatches++;
        $display("Sent %0d loads and %0d relocates under nine register settings;",
                 n_loads, n_relocs);
        $display("%0d result beats checked, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
